FILE: hdl/earf_pkg.sv
// Shared types and constants for the encoder angle and rate filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package earf_pkg;

   // Defaults of the top-level parameters
   localparam int COUNT_CENTER_DEFAULT = 16383;
   localparam int RATE_SCALE_DEFAULT   = 50;

   // Field widths
   localparam int COUNT_W = 16;
   localparam int WORD_W  = 32;
   localparam int COEF_W  = 18;
   localparam int FRAC_W  = 16;
   localparam int RATE_FRAC_W = 8;

   // Filter datapath widths: x + 2x1 + x2 needs two extra bits
   localparam int FF_W   = WORD_W + 2;
   localparam int P_B0_W = COEF_W + FF_W;
   localparam int P_FB_W = COEF_W + WORD_W;
   localparam int ACC_W  = P_B0_W + 2;
   localparam int SHR_W  = ACC_W - FRAC_W;

   // Configuration port
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_ANGLE = 2'd0,
      CSR_GAIN_B0     = 2'd1,
      CSR_FEEDBACK_A1 = 2'd2,
      CSR_FEEDBACK_A2 = 2'd3
   } csr_index_type;

   // Register reset values
   localparam logic signed [WORD_W-1:0] START_ANGLE_RESET = 32'sd720;
   localparam logic signed [COEF_W-1:0] GAIN_B0_RESET     = 18'sd4421;
   localparam logic signed [COEF_W-1:0] FEEDBACK_A1_RESET = 18'sd74907;
   localparam logic signed [COEF_W-1:0] FEEDBACK_A2_RESET = -18'sd27053;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [COUNT_W-1:0] encoder_count;
      logic               clear_history;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] angle_qdeg;
      logic signed [WORD_W-1:0] rate_raw;
      logic signed [WORD_W-1:0] rate_filtered;
   } rsp_type;

   // Per-request step control from the top level to the datapath
   typedef struct packed {
      logic advance;
      logic clear_history;
   } step_ctl_type;

   // Angle preset from a start_angle write
   typedef struct packed {
      logic              load;
      logic [WORD_W-1:0] value;
   } angle_load_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

endpackage

`default_nettype wire

FILE: hdl/earf_front.sv
// Step count, angle accumulator and raw rate for one encoder request.
// Depends on earf_pkg.
`default_nettype none

module earf_front
   import earf_pkg::*;
#(
   parameter int COUNT_CENTER = COUNT_CENTER_DEFAULT,
   parameter int RATE_SCALE   = RATE_SCALE_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire step_ctl_type             ctl,
   input  wire angle_load_type           preset,
   input  wire logic [COUNT_W-1:0]       encoder_count,
   output logic signed [WORD_W-1:0]      angle_next,
   output logic signed [WORD_W-1:0]      rate_raw
);

   localparam int SCALE_W = $clog2(RATE_SCALE + 1) + 1;
   localparam int PROD_W  = COUNT_W + SCALE_W;
   localparam int WIDE_W  = PROD_W + RATE_FRAC_W;
   localparam int EXT_W   = (WIDE_W > WORD_W + 1) ? WIDE_W : WORD_W + 1;
   localparam logic [COUNT_W-1:0]        CENTER  = COUNT_W'(COUNT_CENTER);
   localparam logic signed [SCALE_W-1:0] SCALE_S = SCALE_W'(RATE_SCALE);

   logic signed [COUNT_W-1:0] delta;
   logic signed [PROD_W-1:0]  scaled;
   logic signed [EXT_W-1:0]   raw_wide;
   logic                      raw_over;
   logic [WORD_W-1:0]         angle_acc_ff;
   logic [WORD_W-1:0]         angle_acc_in;

   // Step count since the last read, modulo 2^16
   assign delta = signed'(encoder_count - CENTER);

   // Scale to deg/s in Q.8 and clamp to the word range
   assign scaled   = delta * SCALE_S;
   assign raw_wide = EXT_W'(scaled) <<< RATE_FRAC_W;
   assign raw_over = raw_wide[EXT_W-1:WORD_W-1] != {(EXT_W-WORD_W+1){raw_wide[EXT_W-1]}};

   always_comb begin
      if (raw_over) begin
         rate_raw = raw_wide[EXT_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
         rate_raw = raw_wide[WORD_W-1:0];
      end
   end

   // Wrapping angle sum
   assign angle_next = signed'(angle_acc_ff + WORD_W'(delta));

   always_comb begin
      angle_acc_in = angle_acc_ff;
      if (preset.load) begin
         angle_acc_in = preset.value;
      end else if (ctl.advance) begin
         angle_acc_in = angle_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_acc_ff <= START_ANGLE_RESET;
      end else begin
         angle_acc_ff <= angle_acc_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/earf_biquad.sv
// Second-order low-pass section y = b0(x + 2x1 + x2) + a1 y1 + a2 y2, Q.16.
// Holds the input and output histories. Depends on earf_pkg.
`default_nettype none

module earf_biquad
   import earf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire step_ctl_type             ctl,
   input  wire coef_type                 coef,
   input  wire logic signed [WORD_W-1:0] x,
   output logic signed [WORD_W-1:0]      y
);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);

   logic signed [WORD_W-1:0] x1_ff, x2_ff, y1_ff, y2_ff;
   logic signed [WORD_W-1:0] x1_in, x2_in, y1_in, y2_in;
   logic signed [WORD_W-1:0] x1, x2, y1, y2;
   logic signed [FF_W-1:0]   ff;
   logic signed [P_B0_W-1:0] p_b0;
   logic signed [P_FB_W-1:0] p_a1;
   logic signed [P_FB_W-1:0] p_a2;
   logic signed [ACC_W-1:0]  acc;
   logic signed [SHR_W-1:0]  shifted;
   logic                     over;

   // Histories as seen by this request, zeroed on a clear
   assign x1 = ctl.clear_history ? '0 : x1_ff;
   assign x2 = ctl.clear_history ? '0 : x2_ff;
   assign y1 = ctl.clear_history ? '0 : y1_ff;
   assign y2 = ctl.clear_history ? '0 : y2_ff;

   // Feed-forward sum and the three parallel products
   assign ff   = FF_W'(x) + (FF_W'(x1) <<< 1) + FF_W'(x2);
   assign p_b0 = coef.b0 * ff;
   assign p_a1 = coef.a1 * y1;
   assign p_a2 = coef.a2 * y2;

   // Round half up, drop the fraction, clamp
   assign acc     = ACC_W'(p_b0) + ACC_W'(p_a1) + ACC_W'(p_a2) + ROUND_HALF;
   assign shifted = SHR_W'(acc >>> FRAC_W);
   assign over    = shifted[SHR_W-1:WORD_W-1] != {(SHR_W-WORD_W+1){shifted[SHR_W-1]}};

   always_comb begin
      if (over) begin
         y = shifted[SHR_W-1] ? WORD_MIN : WORD_MAX;
      end else begin
         y = shifted[WORD_W-1:0];
      end
   end

   // Shift the histories when the request moves on
   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (ctl.advance) begin
         x1_in = x;
         x2_in = x1;
         y1_in = y;
         y2_in = y1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/encoder_angle_rate_filter.sv
// Encoder angle and rate filter: the input register is loaded at the edge that accepts
// a request, the result register, which drives rsp_valid, when that request advances,
// which a held result can delay; throughput one request per cycle while rsp_stall holds
// no result, set by the filter feedback through the history registers.
// Synchronous active-high reset empties both registers, loads the angle with 720
// and the filter coefficients with their defaults, and zeroes the filter history.
// Depends on earf_pkg, earf_front and earf_biquad.
`default_nettype none

module encoder_angle_rate_filter
   import earf_pkg::*;
#(
   parameter int COUNT_CENTER = COUNT_CENTER_DEFAULT,
   parameter int RATE_SCALE   = RATE_SCALE_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [WORD_W-1:0]      csr_write_data
);

   logic           in_valid_ff, in_valid_in;
   req_type        in_data_ff, in_data_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_data_ff, out_data_in;
   coef_type       coef_ff, coef_in;
   logic           accept;
   step_ctl_type   ctl;
   angle_load_type preset;
   logic signed [WORD_W-1:0] angle_next;
   logic signed [WORD_W-1:0] rate_raw;
   logic signed [WORD_W-1:0] rate_filtered;

   // Handshake: the input register moves on whenever the result register is free
   assign ctl.advance       = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign ctl.clear_history = in_data_ff.clear_history;
   assign req_stall         = in_valid_ff && !ctl.advance;
   assign accept            = req_valid && !req_stall;

   // Configuration writes
   always_comb begin
      coef_in      = coef_ff;
      preset.load  = 1'b0;
      preset.value = csr_write_data;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_ANGLE: begin
               preset.load = 1'b1;
            end
            CSR_GAIN_B0: begin
               coef_in.b0 = csr_write_data[COEF_W-1:0];
            end
            CSR_FEEDBACK_A1: begin
               coef_in.a1 = csr_write_data[COEF_W-1:0];
            end
            CSR_FEEDBACK_A2: begin
               coef_in.a2 = csr_write_data[COEF_W-1:0];
            end
            default: begin
               coef_in = coef_ff;
            end
         endcase
      end
   end

   // Input register
   always_comb begin
      in_data_in  = accept ? req_data : in_data_ff;
      in_valid_in = accept || (in_valid_ff && !ctl.advance);
   end

   // Result register
   always_comb begin
      out_data_in.angle_qdeg    = angle_next;
      out_data_in.rate_raw      = rate_raw;
      out_data_in.rate_filtered = rate_filtered;
      out_valid_in = ctl.advance || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         coef_ff.b0   <= GAIN_B0_RESET;
         coef_ff.a1   <= FEEDBACK_A1_RESET;
         coef_ff.a2   <= FEEDBACK_A2_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         coef_ff      <= coef_in;
      end
   end

   // Payload registers: hold unless loaded
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      if (ctl.advance) begin
         out_data_ff <= out_data_in;
      end
   end

   earf_front #(
      .COUNT_CENTER (COUNT_CENTER),
      .RATE_SCALE   (RATE_SCALE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .preset        (preset),
      .encoder_count (in_data_ff.encoder_count),
      .angle_next    (angle_next),
      .rate_raw      (rate_raw)
   );

   earf_biquad u_biquad (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .coef  (coef_ff),
      .x     (rate_raw),
      .y     (rate_filtered)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A request that moves on is offered as a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      ctl.advance |=> rsp_valid)
      else $error("advanced request not presented as a result");

   // Back-pressure only when the result register is held
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with a free result register");

   // An empty result register never stalls the request side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled while no result is waiting");

endmodule

`default_nettype wire

FILE: tb/sv/encoder_angle_rate_filter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for encoder_angle_rate_filter: directed and random sample
// ticks, random idling on both channels, results checked against a local filter model
// or typed plan results. Depends on earf_pkg and the encoder_angle_rate_filter RTL.

module encoder_angle_rate_filter_tb;
   import earf_pkg::*;

   localparam int COUNT_CENTER = COUNT_CENTER_DEFAULT;
   localparam int RATE_SCALE   = RATE_SCALE_DEFAULT;

   localparam int          RESET_CYCLES    = 10;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int unsigned CYCLE_LIMIT     = 500000;
   localparam int          RANDOM_PHASES   = 8;
   localparam int          TICKS_PER_PHASE = 144;
   localparam int          REPORT_LIMIT    = 200;

   localparam logic [WORD_W-1:0] COEF_MAX_WORD = 32'h0001_ffff;
   localparam logic [WORD_W-1:0] COEF_MIN_WORD = 32'hfffe_0000;
   localparam longint            ROUND_HALF    = longint'(1) <<< (FRAC_W - 1);

   typedef enum bit {ROW_REQUEST, ROW_WRITE} row_kind_type;

   // One directed step: a register write or a request, with an optional typed result
   typedef struct packed {
      row_kind_type       kind;
      csr_index_type      sel;
      logic [WORD_W-1:0]  value;
      logic [COUNT_W-1:0] count;
      logic               clear;
      logic               typed;
      logic [WORD_W-1:0]  angle;
      logic [WORD_W-1:0]  raw;
      logic [WORD_W-1:0]  filt;
   } plan_row_type;

   localparam plan_row_type DIRECTED_PLAN [0:29] = '{
      // reset settings: zero step, clear, extremes of the count
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h3fff, 1'b0, 1'b1, 32'sd720, 32'sd0, 32'sd0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h3fff, 1'b1, 1'b1, 32'sd720, 32'sd0, 32'sd0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hffff, 1'b1, 1'b1,
        -32'sd15664, -32'sd209715200, -32'sd14147200},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h0000, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hbfff, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hbffe, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h4000, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h3fff, 1'b1, 1'b1, -32'sd32047, 32'sd0, 32'sd0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h3ffe, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h4063, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h4063, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h4063, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h4063, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      // angle just under the top, coefficients at their extremes: wrap up, saturate
      '{ROW_WRITE, CSR_START_ANGLE, 32'h7fff_fff0, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_WRITE, CSR_GAIN_B0, COEF_MAX_WORD, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_WRITE, CSR_FEEDBACK_A1, COEF_MIN_WORD, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_WRITE, CSR_FEEDBACK_A2, COEF_MAX_WORD, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h3fff, 1'b1, 1'b1, 32'h7fff_fff0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hbffe, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hbfff, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hffff, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h0000, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      // angle at the bottom, opposite extremes: wrap down
      '{ROW_WRITE, CSR_START_ANGLE, 32'h8000_0000, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_WRITE, CSR_GAIN_B0, COEF_MIN_WORD, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_WRITE, CSR_FEEDBACK_A1, COEF_MAX_WORD, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_WRITE, CSR_FEEDBACK_A2, COEF_MIN_WORD, 16'h0, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h3fff, 1'b1, 1'b1, 32'h8000_0000, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'h0000, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hffff, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0},
      '{ROW_REQUEST, CSR_START_ANGLE, 32'h0, 16'hbfff, 1'b0, 1'b0, 32'h0, 32'h0, 32'h0}
   };

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   req_type                req_data         = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [WORD_W-1:0]      csr_write_data   = '0;

   // Filter model state and coefficients
   logic [WORD_W-1:0]        model_angle = START_ANGLE_RESET;
   logic signed [WORD_W-1:0] raw_hist1   = '0;
   logic signed [WORD_W-1:0] raw_hist2   = '0;
   logic signed [WORD_W-1:0] filt_hist1  = '0;
   logic signed [WORD_W-1:0] filt_hist2  = '0;
   logic signed [COEF_W-1:0] gain_b0     = GAIN_B0_RESET;
   logic signed [COEF_W-1:0] gain_a1     = FEEDBACK_A1_RESET;
   logic signed [COEF_W-1:0] gain_a2     = FEEDBACK_A2_RESET;

   rsp_type     pending_samples[$];
   int          mismatches  = 0;
   int          gap_mode    = 1;
   int          stall_mode  = 1;
   int unsigned cycle_count = 0;

   encoder_angle_rate_filter #(
      .COUNT_CENTER(COUNT_CENTER),
      .RATE_SCALE  (RATE_SCALE)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int unsigned idle_length(input int mode);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (mode == 0) return 0;
      if (roll < ((mode == 1) ? 60 : 30)) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic logic signed [WORD_W-1:0] saturate(input longint v);
      if (v > longint'(WORD_MAX)) return WORD_MAX;
      if (v < longint'(WORD_MIN)) return WORD_MIN;
      return WORD_W'(v);
   endfunction

   // Advance the model by one sample tick and return the reading it gives
   function automatic rsp_type predict_sample(input req_type tick);
      logic signed [COUNT_W-1:0] step;
      logic signed [WORD_W-1:0]  raw;
      logic signed [WORD_W-1:0]  filt;
      longint                    feed;
      longint                    acc;
      rsp_type                   result;
      if (tick.clear_history) begin
         raw_hist1  = '0;
         raw_hist2  = '0;
         filt_hist1 = '0;
         filt_hist2 = '0;
      end
      step = tick.encoder_count - COUNT_W'(COUNT_CENTER);
      model_angle = model_angle + {{(WORD_W - COUNT_W){step[COUNT_W-1]}}, step};
      raw = saturate(longint'(step) * RATE_SCALE * (longint'(1) <<< RATE_FRAC_W));
      feed = longint'(raw) + 2 * longint'(raw_hist1) + longint'(raw_hist2);
      acc = longint'(gain_b0) * feed + longint'(gain_a1) * longint'(filt_hist1)
          + longint'(gain_a2) * longint'(filt_hist2);
      filt = saturate((acc + ROUND_HALF) >>> FRAC_W);
      raw_hist2  = raw_hist1;
      raw_hist1  = raw;
      filt_hist2 = filt_hist1;
      filt_hist1 = filt;
      result.angle_qdeg    = model_angle;
      result.rate_raw      = raw;
      result.rate_filtered = filt;
      return result;
   endfunction

   function automatic void check_field(input string name, input logic signed [WORD_W-1:0] want,
                                       input logic signed [WORD_W-1:0] got);
      if (got !== want) begin
         if (mismatches < REPORT_LIMIT)
            $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Write one register once the block has drained; the next step lowers the enable
   task automatic write_register(input csr_index_type sel, input logic [WORD_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_write_data   <= value;
      @(posedge clock);
      case (sel)
         CSR_START_ANGLE: model_angle = value;
         CSR_GAIN_B0:     gain_b0 = value[COEF_W-1:0];
         CSR_FEEDBACK_A1: gain_a1 = value[COEF_W-1:0];
         CSR_FEEDBACK_A2: gain_a2 = value[COEF_W-1:0];
         default: ;
      endcase
   endtask

   // Present one request after a random gap and hold it until accepted
   task automatic send_tick(input req_type tick, input bit typed, input rsp_type typed_result);
      int unsigned gap;
      rsp_type     predicted;
      gap = idle_length(gap_mode);
      csr_write_enable <= 1'b0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= tick;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_sample(tick);
      pending_samples.push_back(typed ? typed_result : predicted);
   endtask

   // Stall the result channel in random runs
   initial begin : rsp_stall_gen
      int unsigned hold;
      forever begin
         hold = idle_length(stall_mode);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_samples.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $error("result with no request outstanding: %h", rsp_data);
            mismatches++;
         end else begin
            want = pending_samples.pop_front();
            check_field("angle_qdeg", want.angle_qdeg, rsp_data.angle_qdeg);
            check_field("rate_raw", want.rate_raw, rsp_data.rate_raw);
            check_field("rate_filtered", want.rate_filtered, rsp_data.rate_filtered);
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      plan_row_type      row;
      req_type           tick;
      rsp_type           typed_result;
      logic [COUNT_W-1:0] last_count;
      logic [WORD_W-1:0] start_word;
      logic [WORD_W-1:0] b0_word;
      logic [WORD_W-1:0] a1_word;
      logic [WORD_W-1:0] a2_word;
      int                pole_a2;

      last_count = COUNT_W'(COUNT_CENTER);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed plan
      foreach (DIRECTED_PLAN[i]) begin
         row = DIRECTED_PLAN[i];
         if (row.kind == ROW_WRITE) begin
            write_register(row.sel, row.value);
         end else begin
            tick.encoder_count         = row.count;
            tick.clear_history         = row.clear;
            typed_result.angle_qdeg    = row.angle;
            typed_result.rate_raw      = row.raw;
            typed_result.rate_filtered = row.filt;
            send_tick(tick, row.typed, typed_result);
         end
      end

      // Random phases, each with fresh settings and idling profile
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0: start_word = $urandom;
            1: start_word = START_ANGLE_RESET;
            2: start_word = WORD_MAX - $urandom_range(0, 1 << 20);
            default: start_word = WORD_MIN + $urandom_range(0, 1 << 20);
         endcase
         case ((phase == 0) ? 0 : $urandom_range(0, 3))
            0: begin
               b0_word = {{(WORD_W - COEF_W){GAIN_B0_RESET[COEF_W-1]}}, GAIN_B0_RESET};
               a1_word = {{(WORD_W - COEF_W){FEEDBACK_A1_RESET[COEF_W-1]}}, FEEDBACK_A1_RESET};
               a2_word = {{(WORD_W - COEF_W){FEEDBACK_A2_RESET[COEF_W-1]}}, FEEDBACK_A2_RESET};
            end
            1: begin
               // full range, upper bits of the write data random too
               b0_word = $urandom;
               a1_word = $urandom;
               a2_word = $urandom;
            end
            2: begin
               // stable low-pass shapes
               pole_a2 = -int'($urandom_range(5000, 60000));
               b0_word = $urandom_range(0, 16384);
               a1_word = $urandom_range(0, 65536 - pole_a2 - 2000);
               a2_word = pole_a2;
            end
            default: begin
               b0_word = $urandom_range(0, 1) ? COEF_MAX_WORD : COEF_MIN_WORD;
               a1_word = $urandom_range(0, 1) ? COEF_MAX_WORD : COEF_MIN_WORD;
               a2_word = $urandom_range(0, 1) ? COEF_MAX_WORD : COEF_MIN_WORD;
            end
         endcase
         write_register(CSR_START_ANGLE, start_word);
         write_register(CSR_GAIN_B0, b0_word);
         write_register(CSR_FEEDBACK_A1, a1_word);
         write_register(CSR_FEEDBACK_A2, a2_word);

         gap_mode   = (phase == 0) ? 0 : $urandom_range(0, 2);
         stall_mode = (phase == 0) ? 0 : $urandom_range(0, 2);

         repeat (TICKS_PER_PHASE) begin
            case ($urandom_range(0, 9))
               0, 1: tick.encoder_count = COUNT_W'($urandom);
               2: tick.encoder_count = last_count;
               default: tick.encoder_count = COUNT_W'(COUNT_CENTER - 200 + $urandom_range(0, 400));
            endcase
            tick.clear_history = ($urandom_range(0, 31) == 0);
            last_count = tick.encoder_count;
            send_tick(tick, 1'b0, '0);
         end
      end

      // Drain and report
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/earf_pkg.sv
hdl/earf_front.sv
hdl/earf_biquad.sv
hdl/encoder_angle_rate_filter.sv
tb/sv/encoder_angle_rate_filter_tb.sv
